FILE: design/length_prefixed_frame_deframer_top_macros.svh
// Assertion macros for the length-prefixed frame deframer checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfd check failed");

// Next-cycle implication, disabled during reset
`define LPFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfd check failed");

`endif

FILE: design/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

    // Deframer phase
    typedef enum logic [1:0]
    {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_ABANDON = 2'd3;

    // Header error codes
    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;

    // Input operations
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION_MIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION_MAX = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH  = 2'd3;

    // Header byte positions (count of bytes already taken)
    localparam logic [3:0] MAGIC_END   = 4'd4;
    localparam logic [3:0] VERSION_END = 4'd6;
    localparam logic [3:0] TYPE_END    = 4'd8;
    localparam logic [3:0] HEADER_LAST = 4'd11;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = 6;

    // Register reset values
    localparam logic [31:0] RST_MAGIC       = 32'd0;
    localparam logic [15:0] RST_VERSION_MIN = 16'd1;
    localparam logic [15:0] RST_VERSION_MAX = 16'd1;
    localparam logic [31:0] RST_MAX_LENGTH  = 32'd1048576;

    typedef struct packed
    {
        logic [31:0] magic_value;
        logic [15:0] version_min;
        logic [15:0] version_max;
        logic [31:0] max_length;
    } cfg_t;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [15:0] frame_type;
        logic [7:0]  payload_byte;
        logic        last;
        logic [1:0]  error_code;
        logic [31:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

FILE: design/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer: byte stream in, classified frame results out.
//
// Input stream s_*: one request per byte, s_tuser is the restart flag and s_tdata the byte.
// Each frame starts with a 12-byte big-endian header (magic, version, type, length).
// Output stream m_*: payload bytes with frame type and length, an empty-frame result,
// a header error with its code, or an abandoned-frame result on restart in mid-payload.
// m_tlast marks the last payload byte and the empty-frame result.
// Throughput: one request per cycle while the queue has room; the header check is made in the cycle
// that takes the twelfth header byte.
// Result path: each result is written to the queue, then moves to the output register
// before it shows on m_tvalid.
// Stall: results wait in a QUEUE_DEPTH-entry queue and the output register; s_tready
// drops only while the queue is full, and nothing is lost or repeated.
// Reset: rst_n clears the phase, header state, queue and output; the configuration
// registers return to magic 0, version range 1..1, length limit 1048576.
// Configuration: cfg_wen with cfg_index and cfg_wdata writes a register at once.
// Depends on lpfd_pkg, lpfd_front, lpfd_queue and lpfd_back.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_deframer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lpfd_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic                                s_tuser,   // [0] operation
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [lpfd_pkg::OUT_TDATA_W-1:0]         m_tdata,   // [15:0] frame_type,
                                                                // [23:16] payload_byte,
                                                                // [25:24] error_code,
                                                                // [57:26] frame_length
    output logic [lpfd_pkg::OUT_TUSER_W-1:0]         m_tuser,   // [1:0] kind
    output logic                                     m_tlast,
    input  wire logic                                cfg_wen,
    input  wire logic [lpfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lpfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    lpfd_pkg::result_t front_res, head_data, out_data;
    logic              front_valid, q_space, head_valid, pop;

    lpfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_space (q_space),
        .res_valid (front_valid),
        .res       (front_res)
    );

    lpfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  (front_res),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    lpfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // Pack the result onto the output stream
    assign m_tdata = {{lpfd_pkg::OUT_PAD_W{1'b0}}, out_data.frame_length, out_data.error_code,
                      out_data.payload_byte, out_data.frame_type};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

`default_nettype wire

FILE: design/lpfd_front.sv
// Front end: configuration registers, header collection and checks, payload classification.
// Depends on lpfd_pkg; pushes result items into lpfd_queue.
`timescale 1ns / 1ps
`default_nettype none

module lpfd_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_op,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                cfg_wen,
    input  wire logic [lpfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lpfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                res_space,
    output logic                                     res_valid,
    output lpfd_pkg::result_t                        res
);

    lpfd_pkg::cfg_t   cfg_reg;
    lpfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       count_reg, count_next;
    logic [31:0]      magic_reg, magic_next;
    logic [15:0]      version_reg, version_next;
    logic [15:0]      type_reg, type_next;
    logic [31:0]      length_reg, length_next;
    logic [31:0]      left_reg, left_next;

    logic        accept;
    logic        header_done;
    logic        last_byte;
    logic        bad_magic, bad_version, bad_length, empty_frame, header_bad;
    logic [31:0] length_shift;

    // Any request is taken while the queue has room
    assign in_ready = res_space;
    assign accept   = in_valid & res_space;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_value <= lpfd_pkg::RST_MAGIC;
            cfg_reg.version_min <= lpfd_pkg::RST_VERSION_MIN;
            cfg_reg.version_max <= lpfd_pkg::RST_VERSION_MAX;
            cfg_reg.max_length  <= lpfd_pkg::RST_MAX_LENGTH;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                lpfd_pkg::REG_MAGIC:       cfg_reg.magic_value <= cfg_wdata;
                lpfd_pkg::REG_VERSION_MIN: cfg_reg.version_min <= cfg_wdata[15:0];
                lpfd_pkg::REG_VERSION_MAX: cfg_reg.version_max <= cfg_wdata[15:0];
                lpfd_pkg::REG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Header checks, evaluated on the twelfth header byte
    always_comb
    begin
        length_shift = {length_reg[23:0], in_byte};
        header_done  = (phase_reg == lpfd_pkg::PH_HEADER) && (count_reg == lpfd_pkg::HEADER_LAST)
                       && (in_op == lpfd_pkg::OP_BYTE);
        last_byte    = (left_reg <= 32'd1);
        bad_magic    = (magic_reg != cfg_reg.magic_value);
        bad_version  = (version_reg < cfg_reg.version_min) || (version_reg > cfg_reg.version_max);
        bad_length   = (length_shift > cfg_reg.max_length);
        empty_frame  = (length_shift == 32'd0);
        header_bad   = bad_magic | bad_version | bad_length;
    end

    // Phase: next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (in_op == lpfd_pkg::OP_RESTART)
            begin
                phase_next = lpfd_pkg::PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    lpfd_pkg::PH_PAYLOAD:
                    begin
                        if (last_byte)
                        begin
                            phase_next = lpfd_pkg::PH_HEADER;
                        end
                    end
                    lpfd_pkg::PH_HEADER:
                    begin
                        if (header_done)
                        begin
                            if (header_bad)
                                phase_next = lpfd_pkg::PH_HALTED;
                            else if (empty_frame)
                                phase_next = lpfd_pkg::PH_HEADER;
                            else
                                phase_next = lpfd_pkg::PH_PAYLOAD;
                        end
                    end
                    lpfd_pkg::PH_HALTED: phase_next = lpfd_pkg::PH_HALTED;
                    default:             phase_next = lpfd_pkg::PH_HEADER;
                endcase
            end
        end
    end

    // Header shift registers and payload byte counter
    always_comb
    begin
        count_next   = count_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        if (accept)
        begin
            if (in_op == lpfd_pkg::OP_RESTART)
            begin
                count_next   = 4'd0;
                magic_next   = 32'd0;
                version_next = 16'd0;
                type_next    = 16'd0;
                length_next  = 32'd0;
                left_next    = 32'd0;
            end
            else
            begin
                case (phase_reg)
                    lpfd_pkg::PH_PAYLOAD:
                    begin
                        if (last_byte)
                        begin
                            count_next = 4'd0;
                            left_next  = 32'd0;
                        end
                        else
                        begin
                            left_next = left_reg - 32'd1;
                        end
                    end
                    lpfd_pkg::PH_HEADER:
                    begin
                        if (count_reg < lpfd_pkg::MAGIC_END)
                            magic_next = {magic_reg[23:0], in_byte};
                        else if (count_reg < lpfd_pkg::VERSION_END)
                            version_next = {version_reg[7:0], in_byte};
                        else if (count_reg < lpfd_pkg::TYPE_END)
                            type_next = {type_reg[7:0], in_byte};
                        else
                            length_next = length_shift;

                        if (header_done)
                        begin
                            count_next = 4'd0;
                            if (!header_bad && !empty_frame)
                                left_next = length_shift;
                        end
                        else
                        begin
                            count_next = 4'(count_reg + 4'd1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result item for this request, if any
    always_comb
    begin
        res_valid        = 1'b0;
        res              = '0;
        res.frame_type   = type_reg;
        res.frame_length = length_reg;
        if (accept)
        begin
            if (in_op == lpfd_pkg::OP_RESTART)
            begin
                if (phase_reg == lpfd_pkg::PH_PAYLOAD)
                begin
                    res_valid = 1'b1;
                    res.kind  = lpfd_pkg::KIND_ABANDON;
                end
            end
            else if (phase_reg == lpfd_pkg::PH_PAYLOAD)
            begin
                res_valid        = 1'b1;
                res.kind         = lpfd_pkg::KIND_PAYLOAD;
                res.payload_byte = in_byte;
                res.last         = last_byte;
            end
            else if (header_done)
            begin
                res_valid        = 1'b1;
                res.frame_length = length_shift;
                if (bad_magic)
                begin
                    res.kind       = lpfd_pkg::KIND_ERROR;
                    res.error_code = lpfd_pkg::ERR_MAGIC;
                end
                else if (bad_version)
                begin
                    res.kind       = lpfd_pkg::KIND_ERROR;
                    res.error_code = lpfd_pkg::ERR_VERSION;
                end
                else if (bad_length)
                begin
                    res.kind       = lpfd_pkg::KIND_ERROR;
                    res.error_code = lpfd_pkg::ERR_LENGTH;
                end
                else if (empty_frame)
                begin
                    res.kind = lpfd_pkg::KIND_EMPTY;
                    res.last = 1'b1;
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lpfd_pkg::PH_HEADER;
            count_reg   <= 4'd0;
            magic_reg   <= 32'd0;
            version_reg <= 16'd0;
            type_reg    <= 16'd0;
            length_reg  <= 32'd0;
            left_reg    <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lpfd_queue.sv
// Result queue between front and back end, first-word-fall-through with registered read.
// Depends on lpfd_pkg for the result item type.
`timescale 1ns / 1ps
`default_nettype none

module lpfd_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lpfd_pkg::result_t push_data,
    output logic                   space,
    input  wire logic              pop,
    output logic                   head_valid,
    output lpfd_pkg::result_t      head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lpfd_pkg::result_t mem [DEPTH];
    lpfd_pkg::result_t head_reg;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign space      = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = head_reg;
    assign do_push    = push & space;
    assign do_pop     = pop & head_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        case ({do_push, do_pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; the head register reads the next head, bypassing a write to that slot
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
        if (do_push && (wr_ptr_reg == rd_ptr_next))
            head_reg <= push_data;
        else
            head_reg <= mem[rd_ptr_next];
    end

endmodule

`default_nettype wire

FILE: design/lpfd_back.sv
// Back end: output register that presents queued result items to the receiver.
// Depends on lpfd_pkg for the result item type.
`timescale 1ns / 1ps
`default_nettype none

module lpfd_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire lpfd_pkg::result_t head_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lpfd_pkg::result_t      out_data
);

    logic              valid_reg, valid_next;
    lpfd_pkg::result_t data_reg;

    // Load when the register is empty or its item goes this cycle
    always_comb
    begin
        pop        = head_valid & (~valid_reg | out_ready);
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/lpfd_checker.sv
// Port-level checks on the deframer output stream, bound to the top level.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_frame_deframer_top_macros.svh"

module lpfd_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [lpfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic [lpfd_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input wire logic                                m_tlast
);

    // A stalled result holds until taken
    `LPFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // tlast only on payload bytes and empty frames
    `LPFD_ASSERT_NOW(a_last_kind, m_tvalid && m_tlast, (m_tuser == lpfd_pkg::KIND_PAYLOAD) || (m_tuser == lpfd_pkg::KIND_EMPTY))

    // An empty frame carries length zero and tlast
    `LPFD_ASSERT_NOW(a_empty_frame, m_tvalid && (m_tuser == lpfd_pkg::KIND_EMPTY), m_tlast && (m_tdata[57:26] == 32'd0))

    // Error code is zero on every kind but a header error
    `LPFD_ASSERT_NOW(a_err_code, m_tvalid && (m_tuser != lpfd_pkg::KIND_ERROR), m_tdata[25:24] == lpfd_pkg::ERR_MAGIC)

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (.*);

`default_nettype wire
